// ===== rtl/oas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the OCBA arm selector.
// Used by oas_math_unit, ocba_arm_selector_unit and the bench; depends on nothing.
package oas_pkg;

    localparam int          MaxArms  = 16;
    localparam logic [39:0] TolReset = 40'd1100;
    localparam logic [63:0] OneQ40   = 64'h0000_0100_0000_0000;
    localparam logic [63:0] GapFloor = 64'd1099512;
    localparam logic [63:0] VarBias  = 64'd65536;
    localparam logic [63:0] Sat64    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [5:0]  FracQ40  = 6'd40;
    localparam logic [5:0]  FracQ16  = 6'd16;

    typedef enum logic [1:0] {
        MU_MUL  = 2'd0,
        MU_DIV  = 2'd1,
        MU_SQRT = 2'd2
    } t_mu_op;

    typedef struct packed {
        logic [31:0] alpha_param;
        logic [31:0] beta_param;
        logic [19:0] sample_count;
        logic [19:0] round_number;
        logic        is_last;
    } t_in_req;

    typedef struct packed {
        logic [3:0] chosen_arm;
        logic       uniform_used;
    } t_out_rsp;

    typedef struct packed {
        logic        start;
        t_mu_op      op;
        logic [63:0] opa;
        logic [63:0] opb;
        logic [5:0]  frac;
    } t_mu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_mu_rsp;

endpackage

// ===== rtl/ocba_arm_selector_unit.sv =====
`timescale 1ns / 1ps
// OCBA arm selector top level: arm stores, pass sequencer, output register.
// Depends on oas_pkg and oas_math_unit.
//
// Usage: arms stream in on the request channel (i_in_valid / o_in_stall),
// one arm per cycle, with posterior alpha/beta and allocation count. The
// request marked is_last closes the set; items past MAX_ARMS are dropped.
// After the last request the block runs four passes over the n arms with one
// shared multiply/divide/sqrt unit and then posts one result (chosen arm and
// uniform flag) on o_out_valid / i_out_stall.
// A set of n >= 2 arms is worked out after its last request, its time
// dominated by the divides. A saturated weight sum replaces the per-arm
// target divide by one shared divide, and a zero posterior skips its mean
// divide. A set of one arm answers in the cycle after the last request.
// The block stalls input while a set is being computed. While a result waits
// on a stalled receiver, arms of the next set still load; only its last
// request is held until the result is taken.
// Reset (synchronous, active low) empties the set, drops any pending result
// and restores tie_tolerance to its default. i_cfg_we writes tie_tolerance.
module ocba_arm_selector_unit #(
    parameter int MAX_ARMS = oas_pkg::MaxArms
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  oas_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output oas_pkg::t_out_rsp o_out_rsp,
    input  logic              i_cfg_we,
    input  logic [39:0]       i_cfg_data
);

    localparam int IW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
    localparam int CW = $clog2(MAX_ARMS + 1);

    typedef enum logic [19:0] {
        S_LOAD   = 20'h00001,
        S_A_RD   = 20'h00002,
        S_A_MEAN = 20'h00004,
        S_A_VMUL = 20'h00008,
        S_A_VDIV = 20'h00010,
        S_A_SQRT = 20'h00020,
        S_B_RD   = 20'h00040,
        S_B_Q1   = 20'h00080,
        S_B_W    = 20'h00100,
        S_B_Q2   = 20'h00200,
        S_B_T    = 20'h00400,
        S_SQ     = 20'h00800,
        S_WB     = 20'h01000,
        S_C_RD   = 20'h02000,
        S_C_ACC  = 20'h04000,
        S_U      = 20'h08000,
        S_D_RD   = 20'h10000,
        S_D_TGT  = 20'h20000,
        S_D_MUL  = 20'h40000,
        S_D_CMP  = 20'h80000
    } t_state;

    t_state  r_state, n_state;
    logic    r_wait, n_wait;
    logic [CW-1:0] r_loaded, r_n;
    logic [IW-1:0] r_idx, r_best, r_chosen;
    logic [63:0]   r_best_mean, r_best_spread, r_m, r_t, r_sterm, r_sum, r_uni;
    logic          r_ovf;
    logic [20:0]   r_total;
    logic [19:0]   r_chosen_cnt;
    logic signed [63:0] r_best_def;
    logic [39:0]   r_tol;
    logic          r_out_valid;
    oas_pkg::t_out_rsp r_out;

    logic [31:0] alpha_mem  [MAX_ARMS];
    logic [31:0] beta_mem   [MAX_ARMS];
    logic [19:0] count_mem  [MAX_ARMS];
    logic [63:0] mean_mem   [MAX_ARMS];
    logic [63:0] spread_mem [MAX_ARMS];
    logic [63:0] weight_mem [MAX_ARMS];
    logic [31:0] r_rd_alpha, r_rd_beta;
    logic [19:0] r_rd_count;
    logic [63:0] r_rd_mean, r_rd_spread, r_rd_weight;

    oas_pkg::t_mu_req mu_req;
    oas_pkg::t_mu_rsp mu_rsp;

    logic          in_acc, out_acc, load_we, mu_done, last;
    logic [CW-1:0] n_cnt;
    logic [32:0]   sum_ab;
    logic [63:0]   diff_mean, gap, w_floor;
    logic [64:0]   sterm_add, sum_add;
    logic          sum_ovf;
    logic signed [63:0] def_cur, def_diff, tol_s;
    logic          take;
    logic          ms_we, w_we;
    logic [IW-1:0] w_addr;

    oas_math_unit u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mu_req),
        .o_rsp   (mu_rsp)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_LOAD) || (r_out_valid && i_in_req.is_last);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign mu_done     = mu_rsp.done;
    assign load_we     = in_acc && (r_loaded < CW'(MAX_ARMS));
    assign n_cnt       = load_we ? (r_loaded + CW'(1)) : r_loaded;
    assign last        = (CW'(r_idx) + CW'(1)) == r_n;

    always_comb begin
        sum_ab    = {1'b0, r_rd_alpha} + {1'b0, r_rd_beta};
        diff_mean = r_best_mean - r_rd_mean;
        gap       = (diff_mean < oas_pkg::GapFloor) ? oas_pkg::GapFloor : diff_mean;
        w_floor   = (r_rd_weight == 64'd0) ? 64'd1 : r_rd_weight;
        sterm_add = {1'b0, r_sterm} + {1'b0, mu_rsp.result};
        sum_add   = {1'b0, r_sum} + {1'b0, w_floor};
        sum_ovf   = r_ovf || sum_add[64];
        def_cur   = $signed(r_t) - $signed({4'b0, r_rd_count, 40'b0});
        def_diff  = def_cur - r_best_def;
        tol_s     = $signed({24'b0, r_tol});
        take      = (r_idx == IW'(0)) || (def_diff > tol_s) ||
                    ((def_diff >= -tol_s) && (r_rd_count < r_chosen_cnt));
    end

    // sequencer and operand selection for the shared unit
    always_comb begin
        n_state    = r_state;
        mu_req     = '0;
        mu_req.op  = oas_pkg::MU_MUL;
        mu_req.frac = oas_pkg::FracQ40;
        ms_we      = 1'b0;
        w_we       = 1'b0;
        w_addr     = r_idx;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_in_req.is_last && n_cnt > CW'(1)) n_state = S_A_RD;
            end
            S_A_RD: n_state = S_A_MEAN;
            S_A_MEAN: begin
                if (sum_ab == 33'd0) begin
                    n_state = S_A_VMUL;
                end else begin
                    mu_req.start = !r_wait;
                    mu_req.op    = oas_pkg::MU_DIV;
                    mu_req.opa   = 64'(r_rd_alpha);
                    mu_req.opb   = 64'(sum_ab);
                    if (mu_done) n_state = S_A_VMUL;
                end
            end
            S_A_VMUL: begin
                mu_req.start = !r_wait;
                mu_req.opa   = r_m;
                mu_req.opb   = oas_pkg::OneQ40 - r_m;
                if (mu_done) n_state = S_A_VDIV;
            end
            S_A_VDIV: begin
                mu_req.start = !r_wait;
                mu_req.op    = oas_pkg::MU_DIV;
                mu_req.opa   = r_t;
                mu_req.opb   = 64'(sum_ab) + oas_pkg::VarBias;
                mu_req.frac  = oas_pkg::FracQ16;
                if (mu_done) n_state = S_A_SQRT;
            end
            S_A_SQRT: begin
                mu_req.start = !r_wait;
                mu_req.op    = oas_pkg::MU_SQRT;
                mu_req.opa   = r_t;
                ms_we        = mu_done;
                if (mu_done) n_state = last ? S_B_RD : S_A_RD;
            end
            S_B_RD: begin
                if (r_idx == r_best) n_state = last ? S_SQ : S_B_RD;
                else n_state = S_B_Q1;
            end
            S_B_Q1: begin
                mu_req.start = !r_wait;
                mu_req.op    = oas_pkg::MU_DIV;
                mu_req.opa   = r_rd_spread;
                mu_req.opb   = gap;
                if (mu_done) n_state = S_B_W;
            end
            S_B_W: begin
                mu_req.start = !r_wait;
                mu_req.opa   = r_t;
                mu_req.opb   = r_t;
                w_we         = mu_done;
                if (mu_done) n_state = S_B_Q2;
            end
            S_B_Q2: begin
                mu_req.start = !r_wait;
                mu_req.op    = oas_pkg::MU_DIV;
                mu_req.opa   = r_t;
                mu_req.opb   = r_rd_spread;
                if (mu_done) n_state = S_B_T;
            end
            S_B_T: begin
                mu_req.start = !r_wait;
                mu_req.opa   = r_t;
                mu_req.opb   = r_t;
                if (mu_done) n_state = last ? S_SQ : S_B_RD;
            end
            S_SQ: begin
                mu_req.start = !r_wait;
                mu_req.op    = oas_pkg::MU_SQRT;
                mu_req.opa   = (r_sterm == 64'd0) ? 64'd1 : r_sterm;
                if (mu_done) n_state = S_WB;
            end
            S_WB: begin
                mu_req.start = !r_wait;
                mu_req.opa   = r_best_spread;
                mu_req.opb   = r_t;
                w_we         = mu_done;
                w_addr       = r_best;
                if (mu_done) n_state = S_C_RD;
            end
            S_C_RD: n_state = S_C_ACC;
            S_C_ACC: begin
                if (last) n_state = sum_ovf ? S_U : S_D_RD;
                else n_state = S_C_RD;
            end
            S_U: begin
                mu_req.start = !r_wait;
                mu_req.op    = oas_pkg::MU_DIV;
                mu_req.opa   = 64'(r_total);
                mu_req.opb   = 64'(r_n);
                if (mu_done) n_state = S_D_RD;
            end
            S_D_RD: n_state = S_D_TGT;
            S_D_TGT: begin
                if (r_ovf) begin
                    n_state = S_D_CMP;
                end else begin
                    mu_req.start = !r_wait;
                    mu_req.op    = oas_pkg::MU_DIV;
                    mu_req.opa   = w_floor;
                    mu_req.opb   = r_sum;
                    if (mu_done) n_state = S_D_MUL;
                end
            end
            S_D_MUL: begin
                mu_req.start = !r_wait;
                mu_req.opa   = r_t;
                mu_req.opb   = {3'b0, r_total, 40'b0};
                if (mu_done) n_state = S_D_CMP;
            end
            S_D_CMP: n_state = last ? S_LOAD : S_D_RD;
            default: n_state = S_LOAD;
        endcase
        n_wait = r_wait;
        if (mu_req.start) n_wait = 1'b1;
        if (mu_done) n_wait = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_wait      <= 1'b0;
            r_loaded    <= '0;
            r_out_valid <= 1'b0;
            r_tol       <= oas_pkg::TolReset;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            if (i_cfg_we) r_tol <= i_cfg_data;
            if (in_acc) r_loaded <= i_in_req.is_last ? CW'(0) : n_cnt;
            if ((in_acc && i_in_req.is_last && n_cnt <= CW'(1)) ||
                (r_state == S_D_CMP && last))
                r_out_valid <= 1'b1;
            else if (out_acc)
                r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_in_req.is_last) begin
                    r_idx   <= '0;
                    r_n     <= n_cnt;
                    r_total <= 21'(i_in_req.round_number) + 21'd1;
                    r_sterm <= 64'd0;
                    r_out   <= '0;
                end
            end
            S_A_MEAN: begin
                if (sum_ab == 33'd0) r_m <= 64'd0;
                else if (mu_done) r_m <= mu_rsp.result;
            end
            S_A_VMUL: if (mu_done) r_t <= mu_rsp.result;
            S_A_VDIV: begin
                if (mu_done) r_t <= (mu_rsp.result == 64'd0) ? 64'd1 : mu_rsp.result;
            end
            S_A_SQRT: begin
                if (mu_done) begin
                    if (r_idx == IW'(0) || r_m > r_best_mean) begin
                        r_best        <= r_idx;
                        r_best_mean   <= r_m;
                        r_best_spread <= mu_rsp.result;
                    end
                    r_idx <= last ? IW'(0) : r_idx + IW'(1);
                end
            end
            S_B_RD: begin
                if (r_idx == r_best) r_idx <= last ? IW'(0) : r_idx + IW'(1);
            end
            S_B_Q1, S_B_W, S_B_Q2, S_SQ: if (mu_done) r_t <= mu_rsp.result;
            S_B_T: begin
                if (mu_done) begin
                    r_sterm <= sterm_add[64] ? oas_pkg::Sat64 : sterm_add[63:0];
                    r_idx   <= last ? IW'(0) : r_idx + IW'(1);
                end
            end
            S_WB: begin
                if (mu_done) begin
                    r_idx <= '0;
                    r_sum <= 64'd0;
                    r_ovf <= 1'b0;
                end
            end
            S_C_ACC: begin
                r_sum <= sum_add[64] ? oas_pkg::Sat64 : sum_add[63:0];
                r_ovf <= sum_ovf;
                r_idx <= last ? IW'(0) : r_idx + IW'(1);
            end
            S_U: if (mu_done) r_uni <= mu_rsp.result;
            S_D_TGT: begin
                if (r_ovf) r_t <= r_uni;
                else if (mu_done) r_t <= mu_rsp.result;
            end
            S_D_MUL: if (mu_done) r_t <= mu_rsp.result;
            S_D_CMP: begin
                if (take) begin
                    r_chosen     <= r_idx;
                    r_chosen_cnt <= r_rd_count;
                    r_best_def   <= def_cur;
                end
                if (last) begin
                    r_out.chosen_arm   <= 4'(take ? r_idx : r_chosen);
                    r_out.uniform_used <= r_ovf;
                end
                r_idx <= last ? IW'(0) : r_idx + IW'(1);
            end
            default: r_t <= r_t;
        endcase
    end

    // arm stores, registered read at the sequencer index
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            alpha_mem[r_loaded[IW-1:0]] <= i_in_req.alpha_param;
            beta_mem[r_loaded[IW-1:0]]  <= i_in_req.beta_param;
            count_mem[r_loaded[IW-1:0]] <= i_in_req.sample_count;
        end
        if (ms_we) begin
            mean_mem[r_idx]   <= r_m;
            spread_mem[r_idx] <= mu_rsp.result;
        end
        if (w_we) weight_mem[w_addr] <= mu_rsp.result;
        r_rd_alpha  <= alpha_mem[r_idx];
        r_rd_beta   <= beta_mem[r_idx];
        r_rd_count  <= count_mem[r_idx];
        r_rd_mean   <= mean_mem[r_idx];
        r_rd_spread <= spread_mem[r_idx];
        r_rd_weight <= weight_mem[r_idx];
    end

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !o_out_valid)
        else $error("result pending during set computation");

    a_unit_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mu_req.start |-> !mu_rsp.busy)
        else $error("math unit started while busy");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CW'(MAX_ARMS))
        else $error("arm count beyond capacity");

    a_best_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (CW'(r_best) < r_n))
        else $error("best arm outside loaded set");

endmodule

// ===== rtl/oas_math_unit.sv =====
`timescale 1ns / 1ps
// Shared iterative Q24.40 unit: saturating multiply, divide and square root.
// Depends on oas_pkg.
module oas_math_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  oas_pkg::t_mu_req i_req,
    output oas_pkg::t_mu_rsp o_rsp
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MUL  = 5'b00010,
        M_DIV  = 5'b00100,
        M_NORM = 5'b01000,
        M_ROOT = 5'b10000
    } t_mu_state;

    t_mu_state    r_state, n_state;
    logic         r_done, n_done;
    logic [6:0]   r_cnt;
    logic [63:0]  r_opa, r_opb;
    logic [127:0] r_acc;
    logic [103:0] r_dq;
    logic [64:0]  r_rem;
    logic [63:0]  r_x, r_res, r_bit;
    logic [5:0]   r_e;
    logic [63:0]  r_result;

    // multiply: one 32x32 partial product per cycle
    logic [31:0]  mul_xs, mul_ys;
    logic [63:0]  mul_pp;
    logic [127:0] mul_sh, mul_acc;
    // divide: restoring, one quotient bit per cycle
    logic [64:0]  div_rem2, div_diff;
    logic         div_ge;
    logic [103:0] div_dq;
    // root
    logic         norm_more;
    logic [63:0]  root_trial, root_res;
    logic         root_ge;
    logic [5:0]   root_sh;

    always_comb begin
        mul_xs  = r_cnt[0] ? r_opa[63:32] : r_opa[31:0];
        mul_ys  = r_cnt[1] ? r_opb[63:32] : r_opb[31:0];
        mul_pp  = 64'(mul_xs) * 64'(mul_ys);
        case (r_cnt[1:0])
            2'd0:    mul_sh = {64'b0, mul_pp};
            2'd3:    mul_sh = {mul_pp, 64'b0};
            default: mul_sh = {32'b0, mul_pp, 32'b0};
        endcase
        mul_acc = r_acc + mul_sh;

        div_rem2 = {r_rem[63:0], r_dq[103]};
        div_ge   = div_rem2 >= {1'b0, r_opb};
        div_diff = div_rem2 - {1'b0, r_opb};
        div_dq   = {r_dq[102:0], div_ge};

        norm_more  = (r_e != 6'd0) && ((r_x >> (7'd64 - 7'(r_e))) != 64'd0);
        root_trial = r_res + r_bit;
        root_ge    = r_x >= root_trial;
        root_res   = root_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        root_sh    = (6'd40 - r_e) >> 1;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        oas_pkg::MU_MUL:  n_state = M_MUL;
                        oas_pkg::MU_DIV:  n_state = M_DIV;
                        oas_pkg::MU_SQRT: n_state = M_NORM;
                        default:          n_state = M_IDLE;
                    endcase
                end
            end
            M_MUL: begin
                if (r_cnt == 7'd3) begin
                    n_state = M_IDLE;
                    n_done  = 1'b1;
                end
            end
            M_DIV: begin
                if (r_cnt == 7'd103) begin
                    n_state = M_IDLE;
                    n_done  = 1'b1;
                end
            end
            M_NORM: begin
                if (!norm_more) n_state = M_ROOT;
            end
            M_ROOT: begin
                if (r_cnt == 7'd31) begin
                    n_state = M_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_cnt <= 7'd0;
                r_opa <= i_req.opa;
                r_opb <= i_req.opb;
                r_acc <= 128'd0;
                r_dq  <= 104'(i_req.opa) << i_req.frac;
                r_rem <= 65'd0;
                r_x   <= i_req.opa;
                r_e   <= 6'd40;
            end
            M_MUL: begin
                r_cnt <= r_cnt + 7'd1;
                r_acc <= mul_acc;
                if (r_cnt == 7'd3)
                    r_result <= (mul_acc[127:104] != 24'd0) ? oas_pkg::Sat64
                                                             : mul_acc[103:40];
            end
            M_DIV: begin
                r_cnt <= r_cnt + 7'd1;
                r_dq  <= div_dq;
                r_rem <= div_ge ? div_diff : div_rem2;
                if (r_cnt == 7'd103)
                    r_result <= (div_dq[103:64] != 40'd0) ? oas_pkg::Sat64
                                                           : div_dq[63:0];
            end
            M_NORM: begin
                if (norm_more) begin
                    r_e <= r_e - 6'd2;
                end else begin
                    r_x   <= r_x << r_e;
                    r_res <= 64'd0;
                    r_bit <= 64'd1 << 62;
                    r_cnt <= 7'd0;
                end
            end
            M_ROOT: begin
                r_cnt <= r_cnt + 7'd1;
                if (root_ge) r_x <= r_x - root_trial;
                r_res <= root_res;
                r_bit <= r_bit >> 2;
                if (r_cnt == 7'd31) r_result <= root_res << root_sh;
            end
            default: r_cnt <= 7'd0;
        endcase
    end

    assign o_rsp.busy   = (r_state != M_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

// ===== bench/ocba_arm_selector_checker.sv =====
`timescale 1ns / 1ps
// Checker for the OCBA arm selector: watches both channels and the config
// port, predicts each set's chosen arm and uniform flag and compares. Depends on oas_pkg.
module ocba_arm_selector_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  oas_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  oas_pkg::t_out_rsp i_out_rsp,
    input  logic              i_cfg_we,
    input  logic [39:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    localparam logic [63:0] SAT = 64'hFFFF_FFFF_FFFF_FFFF;

    logic [39:0]       tol_q;
    logic [31:0]       alpha_q [oas_pkg::MaxArms];
    logic [31:0]       beta_q  [oas_pkg::MaxArms];
    logic [19:0]       count_q [oas_pkg::MaxArms];
    int                n_loaded;
    oas_pkg::t_out_rsp picks_due [$];

    assign o_pending = picks_due.size();

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = ({64'b0, x} * {64'b0, y}) >> 40;
        return (p[127:64] != 0) ? SAT : p[63:0];
    endfunction

    function automatic logic [63:0] fx_div(input logic [63:0] num, input logic [63:0] den,
                                           input int fb);
        logic [127:0] q;
        q = ({64'b0, num} << fb) / {64'b0, den};
        return (q[127:64] != 0) ? SAT : q[63:0];
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] fx_sqrt(input logic [63:0] x);
        int e;
        e = 40;
        while (e > 0 && (x >> (64 - e)) != 0) e -= 2;
        return int_root(x << e) << ((40 - e) / 2);
    endfunction

    // one accepted request; a last request closes the set and yields a pick
    task automatic load_arm(input oas_pkg::t_in_req r);
        logic [63:0] mean [oas_pkg::MaxArms];
        logic [63:0] sig [oas_pkg::MaxArms];
        logic [63:0] wt [oas_pkg::MaxArms];
        logic [63:0] tgt [oas_pkg::MaxArms];
        logic [63:0] s, m, v, gap, q, sterm, sum, total;
        logic signed [63:0] best_def, d, diff, tol;
        logic ovf;
        int n, best, pick;
        oas_pkg::t_out_rsp rsp;
        if (n_loaded < oas_pkg::MaxArms) begin
            alpha_q[n_loaded] = r.alpha_param;
            beta_q[n_loaded] = r.beta_param;
            count_q[n_loaded] = r.sample_count;
            n_loaded++;
        end
        if (!r.is_last) return;
        n = n_loaded;
        n_loaded = 0;
        total = 64'(r.round_number) + 1;
        rsp = '0;
        if (n > 1) begin
            for (int i = 0; i < n; i++) begin
                s = 64'(alpha_q[i]) + 64'(beta_q[i]);
                m = (s != 0) ? fx_div(64'(alpha_q[i]), s, 40) : 64'd0;
                v = fx_div(fx_mul(m, oas_pkg::OneQ40 - m), s + oas_pkg::VarBias, 16);
                if (v < 1) v = 1;
                mean[i] = m;
                sig[i] = fx_sqrt(v);
            end
            best = 0;
            for (int i = 1; i < n; i++) if (mean[i] > mean[best]) best = i;
            sterm = 0;
            for (int i = 0; i < n; i++) begin
                if (i == best) continue;
                gap = mean[best] - mean[i];
                if (gap < oas_pkg::GapFloor) gap = oas_pkg::GapFloor;
                q = fx_div(sig[i], gap, 40);
                wt[i] = fx_mul(q, q);
                q = fx_div(wt[i], sig[i], 40);
                q = fx_mul(q, q);
                sterm = (sterm > SAT - q) ? SAT : sterm + q;
            end
            if (sterm < 1) sterm = 1;
            wt[best] = fx_mul(sig[best], fx_sqrt(sterm));
            sum = 0;
            ovf = 0;
            for (int i = 0; i < n; i++) begin
                if (wt[i] < 1) wt[i] = 1;
                if (sum > SAT - wt[i]) begin
                    ovf = 1;
                    sum = SAT;
                end else begin
                    sum += wt[i];
                end
            end
            for (int i = 0; i < n; i++)
                tgt[i] = ovf ? fx_div(total, 64'(n), 40) : fx_div(wt[i], sum, 40) * total;
            tol = $signed({24'b0, tol_q});
            pick = 0;
            best_def = $signed(tgt[0]) - $signed({4'b0, count_q[0], 40'b0});
            for (int i = 1; i < n; i++) begin
                d = $signed(tgt[i]) - $signed({4'b0, count_q[i], 40'b0});
                diff = d - best_def;
                if (diff > tol) begin
                    pick = i;
                    best_def = d;
                    continue;
                end
                if (diff < 0) diff = -diff;
                if (diff <= tol && count_q[i] < count_q[pick]) begin
                    pick = i;
                    best_def = d;
                end
            end
            rsp.chosen_arm = 4'(pick);
            rsp.uniform_used = ovf;
        end
        picks_due.push_back(rsp);
    endtask

    // sample mid-cycle: whatever is seen here is taken at the coming edge
    always @(negedge i_clk) begin
        oas_pkg::t_out_rsp want;
        if (!i_rst_n) begin
            tol_q = oas_pkg::TolReset;
            n_loaded = 0;
            o_errors = 0;
            picks_due.delete();
        end else begin
            if (i_cfg_we) tol_q = i_cfg_data;
            if (i_in_valid && !i_in_stall) load_arm(i_in_req);
            if (i_out_valid && !i_out_stall) begin
                if (picks_due.size() == 0) begin
                    report($sformatf("unexpected result arm=%0d uniform=%0b",
                                     i_out_rsp.chosen_arm, i_out_rsp.uniform_used));
                end else begin
                    want = picks_due.pop_front();
                    if (i_out_rsp.chosen_arm !== want.chosen_arm)
                        report($sformatf("chosen_arm %0d, expected %0d",
                                         i_out_rsp.chosen_arm, want.chosen_arm));
                    if (i_out_rsp.uniform_used !== want.uniform_used)
                        report($sformatf("uniform_used %0b, expected %0b",
                                         i_out_rsp.uniform_used, want.uniform_used));
                end
            end
        end
    end
endmodule

// ===== bench/tb_ocba_arm_selector_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for ocba_arm_selector_unit: clock, reset, arm-set stimulus,
// tolerance writes and verdict. Depends on oas_pkg and the checker module.
module tb_ocba_arm_selector_unit;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_stall;
    oas_pkg::t_in_req  in_req;
    logic              out_valid;
    logic              out_stall;
    oas_pkg::t_out_rsp out_rsp;
    logic              cfg_we;
    logic [39:0]       cfg_data;
    int                errors;
    int                pending;
    bit                calm;
    bit                hold_req;

    ocba_arm_selector_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_req(in_req),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_rsp(out_rsp),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    ocba_arm_selector_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_req(in_req),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_rsp(out_rsp),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        bit held;
        held = 0;
        out_stall = 1'b0;
        forever begin
            if (hold_req && !held) begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                held = 1;
            end else if (calm) begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 17);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_arm(input oas_pkg::t_in_req r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do @(negedge i_clk); while (in_stall);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_param();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return {16'($urandom_range(0, 200)), 16'($urandom)};
        endcase
    endfunction

    task automatic send_set(input int n_arms);
        oas_pkg::t_in_req r, twin;
        bit dup;
        dup = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_arms; i++) begin
            r.alpha_param = rand_param();
            r.beta_param = rand_param();
            if (dup && i > 0) begin
                r.alpha_param = twin.alpha_param;
                r.beta_param = twin.beta_param;
            end
            r.sample_count = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                         : 20'($urandom_range(0, 40));
            r.round_number = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                         : 20'($urandom_range(0, 400));
            r.is_last = (i == n_arms - 1);
            if (i == 0) twin = r;
            send_arm(r);
        end
    endtask

    task automatic write_tol(input logic [39:0] v);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [39:0] tols [5];
        int sent, k;
        in_valid = 1'b0;
        in_req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        calm = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single arm, zero posterior, extremes, identical arms
        send_arm('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 1'b1});
        send_arm('{32'd0, 32'd0, 20'd0, 20'd0, 1'b0});
        send_arm('{32'h0001_0000, 32'h0003_0000, 20'd2, 20'd0, 1'b0});
        send_arm('{32'hFFFF_FFFF, 32'd0, 20'hFFFFF, 20'd9, 1'b1});
        send_arm('{32'h0001_0000, 32'h0001_0000, 20'd3, 20'd50, 1'b0});
        send_arm('{32'h0001_0000, 32'h0001_0000, 20'd3, 20'd50, 1'b0});
        send_arm('{32'h0001_0000, 32'h0001_0000, 20'd1, 20'd50, 1'b1});
        send_arm('{32'h0005_0000, 32'h0002_0000, 20'd0, 20'd0, 1'b0});
        send_arm('{32'h0002_0000, 32'h0005_0000, 20'd0, 20'hFFFFF, 1'b1});

        tols = '{oas_pkg::TolReset, 40'd0, 40'hFF_FFFF_FFFF, 40'($urandom), 40'd1};
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_tol(tols[ph]);
            if (ph == 4) calm = 1;
            while (sent < (ph + 1) * 100) begin
                if (ph == 1 && sent >= 120) hold_req = 1;
                case ($urandom_range(0, 19))
                    0: k = $urandom_range(17, 19);
                    1, 2: k = $urandom_range(6, 16);
                    default: k = $urandom_range(1, 5);
                endcase
                send_set(k);
                sent += k;
            end
        end
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
